// ===== rtl/pixel_blend_mode_unit_defines.svh =====
// Assertion macros for the pixel blend mode unit.
// Included by the top level; no other dependencies.
`ifndef PIXEL_BLEND_MODE_UNIT_DEFINES_SVH
`define PIXEL_BLEND_MODE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PBM_ASSERT_IMP(lbl, clk_s, rst_ns, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
    else $error("pbm assertion failed");
`define PBM_ASSERT_NXT(lbl, clk_s, rst_ns, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
    else $error("pbm assertion failed");
`else
`define PBM_ASSERT_IMP(lbl, clk_s, rst_ns, ante, cons)
`define PBM_ASSERT_NXT(lbl, clk_s, rst_ns, ante, cons)
`endif
`endif

// ===== rtl/pbm_pkg.sv =====
// Types and constants for the pixel blend mode unit.
// No dependencies.
`default_nettype none
package pbm_pkg;
  typedef enum logic [3:0] {
    MODE_ADD_SCALED = 4'd0,
    MODE_ADD_MOD    = 4'd1,
    MODE_LERP       = 4'd2,
    MODE_COMPOSITE  = 4'd3,
    MODE_MIN        = 4'd4,
    MODE_ABSDIFF    = 4'd5,
    MODE_DIVIDE     = 4'd6,
    MODE_MAX        = 4'd7,
    MODE_MULTIPLY   = 4'd8,
    MODE_OVERLAY    = 4'd9,
    MODE_SCREEN     = 4'd10,
    MODE_SUB_SCALED = 4'd11,
    MODE_SUB_MOD    = 4'd12,
    MODE_AND        = 4'd13,
    MODE_OR         = 4'd14,
    MODE_XOR        = 4'd15
  } pbm_mode_t;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_GAIN  = 3'd1;
  localparam logic [2:0] REG_BIAS  = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;
  localparam logic [2:0] REG_CH_A  = 3'd4;
  localparam logic [2:0] REG_CH_B  = 3'd5;

  localparam int NUM_CH = 4;

  typedef struct packed {
    logic [7:0] a_ch0;
    logic [7:0] a_ch1;
    logic [7:0] a_ch2;
    logic [7:0] a_ch3;
    logic [7:0] b_ch0;
    logic [7:0] b_ch1;
    logic [7:0] b_ch2;
    logic [7:0] b_ch3;
  } pbm_in_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_ch3;
  } pbm_out_t;

  typedef struct packed {
    pbm_mode_t          mode;
    logic [15:0]        gain;
    logic signed [10:0] bias;
    logic [8:0]         weight;
    logic               copy_b;
  } pbm_cfg_t;
endpackage
`default_nettype wire

// ===== rtl/pbm_lane.sv =====
// One channel lane: products, scaling, divide-by-255 and a two-stage divider.
// Depends on pbm_pkg.
`default_nettype none
module pbm_lane (
  input  wire logic           clk,
  input  wire logic           en1,
  input  wire logic           en2,
  input  wire logic           en3,
  input  wire pbm_pkg::pbm_cfg_t cfg,
  input  wire logic [7:0]     a,
  input  wire logic [7:0]     b,
  input  wire logic [7:0]     alpha_b,
  output logic [7:0]          res
);
  logic signed [26:0] p_r, p_nxt;
  logic [16:0]        n_r, n_nxt;
  logic [7:0]         simple_r, simple_nxt;
  logic [7:0]         b1_r;

  logic [7:0] res2_r, res2_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [3:0] qhi_r, qhi_nxt;
  logic [3:0] dlo_r;
  logic [7:0] b2_r;
  logic       sat_r, sat_nxt;

  logic [7:0] res3_r, res3_nxt;

  // stage 1
  always_comb begin
    logic signed [9:0] s;
    logic [16:0] ax, bx, lx, wx;
    ax = {9'b0, a};
    bx = {9'b0, b};
    lx = {9'b0, alpha_b};
    wx = {8'b0, cfg.weight};
    if (cfg.mode == pbm_pkg::MODE_SUB_SCALED) begin
      s = $signed({2'b0, a}) - $signed({2'b0, b});
    end else begin
      s = $signed({2'b0, a}) + $signed({2'b0, b});
    end
    p_nxt = 27'(s * $signed({1'b0, cfg.gain}));
    case (cfg.mode)
      pbm_pkg::MODE_LERP:      n_nxt = ax * (17'd256 - wx) + bx * wx;
      pbm_pkg::MODE_COMPOSITE: n_nxt = ax * (17'd255 - lx) + bx * lx;
      pbm_pkg::MODE_DIVIDE:    n_nxt = ax * 17'd255;
      pbm_pkg::MODE_MULTIPLY:  n_nxt = ax * bx;
      pbm_pkg::MODE_OVERLAY: begin
        if (b < 8'd128) begin
          n_nxt = 17'd2 * ax * bx;
        end else begin
          n_nxt = 17'd65025 - 17'd2 * (17'd255 - ax) * (17'd255 - bx);
        end
      end
      pbm_pkg::MODE_SCREEN:    n_nxt = 17'd65025 - (17'd255 - ax) * (17'd255 - bx);
      default:                 n_nxt = '0;
    endcase
    case (cfg.mode)
      pbm_pkg::MODE_ADD_MOD: simple_nxt = a + b;
      pbm_pkg::MODE_SUB_MOD: simple_nxt = a - b;
      pbm_pkg::MODE_MIN:     simple_nxt = (a < b) ? a : b;
      pbm_pkg::MODE_MAX:     simple_nxt = (a > b) ? a : b;
      pbm_pkg::MODE_ABSDIFF: simple_nxt = (a > b) ? a - b : b - a;
      pbm_pkg::MODE_AND:     simple_nxt = a & b;
      pbm_pkg::MODE_OR:      simple_nxt = a | b;
      pbm_pkg::MODE_XOR:     simple_nxt = a ^ b;
      default:               simple_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p_r      <= p_nxt;
      n_r      <= n_nxt;
      simple_r <= simple_nxt;
      b1_r     <= b;
    end
  end

  // stage 2
  always_comb begin
    logic signed [26:0] q;
    logic signed [20:0] r;
    logic [7:0]  clamped;
    logic [8:0]  q0;
    logic [9:0]  rm;
    logic [8:0]  d255;
    logic [8:0]  t;
    logic [7:0]  rem;
    q = p_r >>> 12;
    r = 21'(q) + 21'($signed(cfg.bias) * 21'sd255);
    if (r < 0) begin
      clamped = 8'd0;
    end else if (r > 21'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = r[7:0];
    end
    q0 = n_r[16:8];
    rm = 10'(n_r[7:0]) + 10'(q0);
    d255 = q0 + 9'(rm >= 10'd255) + 9'(rm >= 10'd510);
    case (cfg.mode)
      pbm_pkg::MODE_ADD_SCALED, pbm_pkg::MODE_SUB_SCALED: res2_nxt = clamped;
      pbm_pkg::MODE_LERP:      res2_nxt = n_r[15:8];
      pbm_pkg::MODE_COMPOSITE: res2_nxt = cfg.copy_b ? b1_r : d255[7:0];
      pbm_pkg::MODE_MULTIPLY, pbm_pkg::MODE_OVERLAY, pbm_pkg::MODE_SCREEN:
        res2_nxt = d255[7:0];
      default:                 res2_nxt = simple_r;
    endcase
    sat_nxt = (b1_r == 8'd0) || (n_r[15:8] >= b1_r);
    rem = n_r[15:8];
    for (int k = 7; k >= 4; k--) begin
      t = {rem, n_r[k]};
      if (t >= {1'b0, b1_r}) begin
        rem = 8'(t - {1'b0, b1_r});
        qhi_nxt[k-4] = 1'b1;
      end else begin
        rem = t[7:0];
        qhi_nxt[k-4] = 1'b0;
      end
    end
    rem_nxt = rem;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res2_r <= res2_nxt;
      rem_r  <= rem_nxt;
      qhi_r  <= qhi_nxt;
      dlo_r  <= n_r[3:0];
      b2_r   <= b1_r;
      sat_r  <= sat_nxt;
    end
  end

  // stage 3
  always_comb begin
    logic [8:0] t;
    logic [7:0] rem;
    logic [3:0] qlo;
    rem = rem_r;
    for (int k = 3; k >= 0; k--) begin
      t = {rem, dlo_r[k]};
      if (t >= {1'b0, b2_r}) begin
        rem = 8'(t - {1'b0, b2_r});
        qlo[k] = 1'b1;
      end else begin
        rem = t[7:0];
        qlo[k] = 1'b0;
      end
    end
    if (cfg.mode == pbm_pkg::MODE_DIVIDE) begin
      res3_nxt = sat_r ? 8'd255 : {qhi_r, qlo};
    end else begin
      res3_nxt = res2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res3_r <= res3_nxt;
    end
  end

  assign res = res3_r;
endmodule
`default_nettype wire

// ===== rtl/pixel_blend_mode_unit.sv =====
// Top level of the pixel blend mode unit: config registers, lanes, merge stage.
// Depends on pbm_pkg, pbm_lane and pixel_blend_mode_unit_defines.svh.
//
//  channel | direction | ports
//  input   | in        | in_valid, in_stall, in_data (pbm_in_t)
//  result  | out       | out_valid, out_stall, out_data (pbm_out_t)
//  config  | APB       | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One pixel per cycle sustained while the output is not stalled; three lane stages, one merge stage.
// The lane divider resolves four quotient bits in each of two stages.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output holds; bubbles ahead of it still fill, so input is taken until the pipe is full.
`default_nettype none
`include "pixel_blend_mode_unit_defines.svh"
module pixel_blend_mode_unit #(
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pbm_pkg::pbm_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pbm_pkg::pbm_out_t      out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  pbm_pkg::pbm_mode_t mode_r;
  logic [15:0]        gain_r;
  logic [10:0]        bias_r;
  logic [8:0]         alpha_r;
  logic [2:0]         cha_r;
  logic [2:0]         chb_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pbm_pkg::MODE_ADD_SCALED;
      gain_r  <= 16'd4096;
      bias_r  <= '0;
      alpha_r <= 9'd128;
      cha_r   <= 3'd4;
      chb_r   <= 3'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        pbm_pkg::REG_MODE:  mode_r  <= pbm_pkg::pbm_mode_t'(pwdata[3:0]);
        pbm_pkg::REG_GAIN:  gain_r  <= pwdata[15:0];
        pbm_pkg::REG_BIAS:  bias_r  <= pwdata[10:0];
        pbm_pkg::REG_ALPHA: alpha_r <= pwdata[8:0];
        pbm_pkg::REG_CH_A:  cha_r   <= pwdata[2:0];
        pbm_pkg::REG_CH_B:  chb_r   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pbm_pkg::REG_MODE:  prdata = {28'b0, mode_r};
      pbm_pkg::REG_GAIN:  prdata = {16'b0, gain_r};
      pbm_pkg::REG_BIAS:  prdata = {21'b0, bias_r};
      pbm_pkg::REG_ALPHA: prdata = {23'b0, alpha_r};
      pbm_pkg::REG_CH_A:  prdata = {29'b0, cha_r};
      pbm_pkg::REG_CH_B:  prdata = {29'b0, chb_r};
      default:            prdata = '0;
    endcase
  end

  localparam logic [2:0] MAXC = 3'(MAX_CHANNELS);

  logic [2:0] ca, cb, cr;
  pbm_pkg::pbm_cfg_t cfg;
  logic [7:0] pa [pbm_pkg::NUM_CH];
  logic [7:0] pb [pbm_pkg::NUM_CH];
  logic [7:0] ia [pbm_pkg::NUM_CH];
  logic [7:0] ib [pbm_pkg::NUM_CH];

  assign ca = (cha_r > MAXC) ? MAXC : cha_r;
  assign cb = (chb_r > MAXC) ? MAXC : chb_r;
  assign cr = (ca > cb) ? ca : cb;

  assign cfg.mode   = mode_r;
  assign cfg.gain   = gain_r;
  assign cfg.bias   = $signed(bias_r);
  assign cfg.weight = (alpha_r > 9'd256) ? 9'd256 : alpha_r;
  assign cfg.copy_b = (mode_r == pbm_pkg::MODE_COMPOSITE) && (cb < 3'd4);

  assign ia[0] = in_data.a_ch0;
  assign ia[1] = in_data.a_ch1;
  assign ia[2] = in_data.a_ch2;
  assign ia[3] = in_data.a_ch3;
  assign ib[0] = in_data.b_ch0;
  assign ib[1] = in_data.b_ch1;
  assign ib[2] = in_data.b_ch2;
  assign ib[3] = in_data.b_ch3;

  always_comb begin
    for (int i = 0; i < pbm_pkg::NUM_CH; i++) begin
      pa[i] = (3'(i) < ca) ? ia[i] : 8'd0;
      pb[i] = (3'(i) < cb) ? ib[i] : 8'd0;
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || !out_stall;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  logic [7:0] lane_res [pbm_pkg::NUM_CH];

  for (genvar g = 0; g < pbm_pkg::NUM_CH; g++) begin : g_lane
    if (g < MAX_CHANNELS) begin : g_on
      pbm_lane u_lane (
        .clk     (clk),
        .en1     (adv1),
        .en2     (adv2),
        .en3     (adv3),
        .cfg     (cfg),
        .a       (pa[g]),
        .b       (pb[g]),
        .alpha_b (pb[3]),
        .res     (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = 8'd0;
    end
  end

  // merge: zero channels beyond the result count
  pbm_pkg::pbm_out_t out_r, out_nxt;
  logic [7:0] m [pbm_pkg::NUM_CH];

  always_comb begin
    for (int i = 0; i < pbm_pkg::NUM_CH; i++) begin
      m[i] = (3'(i) < cr) ? lane_res[i] : 8'd0;
    end
    out_nxt.out_ch0 = m[0];
    out_nxt.out_ch1 = m[1];
    out_nxt.out_ch2 = m[2];
    out_nxt.out_ch3 = m[3];
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

  `PBM_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, v1_r)
  `PBM_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, v1_r && v2_r && v3_r && v4_r)
  `PBM_ASSERT_NXT(a_drain, clk, rst_n, out_valid && !out_stall && !v3_r, !out_valid)
endmodule
`default_nettype wire

// ===== tb/pixel_blend_mode_unit_tb.sv =====
// Testbench for pixel_blend_mode_unit: random and directed pixel pairs under several
// register settings, results checked by a scoreboard class against a local blend predictor.
// Depends on pbm_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module pixel_blend_mode_unit_tb;

  class blend_scoreboard;
    pbm_pkg::pbm_out_t expected_pixels[$];
    int errors;

    logic [3:0]  mode;
    logic [15:0] gain;
    logic [10:0] bias;
    logic [8:0]  alpha;
    logic [2:0]  ch_a;
    logic [2:0]  ch_b;

    function new();
      errors = 0;
      mode = pbm_pkg::MODE_ADD_SCALED;
      gain = 16'd4096;
      bias = '0;
      alpha = 9'd128;
      ch_a = 3'd4;
      ch_b = 3'd4;
    endfunction

    function int scaled_value(int s);
      int p;
      int q;
      int r;
      p = s * int'(gain);
      if (p >= 0) q = p >>> 12;
      else q = -((-p + 4095) >>> 12);
      r = q + int'($signed(bias)) * 255;
      if (r < 0) return 0;
      if (r > 255) return 255;
      return r;
    endfunction

    function int blend_one(int a, int b, int ab);
      int w;
      case (pbm_pkg::pbm_mode_t'(mode))
        pbm_pkg::MODE_ADD_SCALED: return scaled_value(a + b);
        pbm_pkg::MODE_ADD_MOD:    return (a + b) & 255;
        pbm_pkg::MODE_LERP: begin
          w = (alpha > 256) ? 256 : int'(alpha);
          return (a * (256 - w) + b * w) >> 8;
        end
        pbm_pkg::MODE_COMPOSITE:  return (a * (255 - ab) + b * ab) / 255;
        pbm_pkg::MODE_MIN:        return a < b ? a : b;
        pbm_pkg::MODE_ABSDIFF:    return a > b ? a - b : b - a;
        pbm_pkg::MODE_DIVIDE: begin
          if (b == 0) return 255;
          w = (255 * a) / b;
          return w > 255 ? 255 : w;
        end
        pbm_pkg::MODE_MAX:        return a > b ? a : b;
        pbm_pkg::MODE_MULTIPLY:   return (a * b) / 255;
        pbm_pkg::MODE_OVERLAY: begin
          if (b < 128) return (2 * a * b) / 255;
          return (65025 - 2 * (255 - a) * (255 - b)) / 255;
        end
        pbm_pkg::MODE_SCREEN:     return (65025 - (255 - a) * (255 - b)) / 255;
        pbm_pkg::MODE_SUB_SCALED: return scaled_value(a - b);
        pbm_pkg::MODE_SUB_MOD:    return (a - b) & 255;
        pbm_pkg::MODE_AND:        return a & b;
        pbm_pkg::MODE_OR:         return a | b;
        default:                  return a ^ b;
      endcase
    endfunction

    function void note_request(pbm_pkg::pbm_in_t d);
      int ca;
      int cb;
      int cr;
      int pa[4];
      int pb[4];
      int r[4];
      bit copy_b;
      ca = ch_a > 4 ? 4 : int'(ch_a);
      cb = ch_b > 4 ? 4 : int'(ch_b);
      cr = ca > cb ? ca : cb;
      copy_b = (mode == pbm_pkg::MODE_COMPOSITE) && cb < 4;
      pa[0] = d.a_ch0; pa[1] = d.a_ch1; pa[2] = d.a_ch2; pa[3] = d.a_ch3;
      pb[0] = d.b_ch0; pb[1] = d.b_ch1; pb[2] = d.b_ch2; pb[3] = d.b_ch3;
      for (int i = 0; i < 4; i++) begin
        if (i >= ca) pa[i] = 0;
        if (i >= cb) pb[i] = 0;
      end
      for (int i = 0; i < 4; i++) begin
        r[i] = 0;
        if (i < cr) r[i] = copy_b ? pb[i] : blend_one(pa[i], pb[i], pb[3]);
      end
      expected_pixels.push_back({r[0][7:0], r[1][7:0], r[2][7:0], r[3][7:0]});
    endfunction

    function void check_result(pbm_pkg::pbm_out_t got);
      pbm_pkg::pbm_out_t exp_px;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (got.out_ch0 !== exp_px.out_ch0 || got.out_ch1 !== exp_px.out_ch1 ||
          got.out_ch2 !== exp_px.out_ch2 || got.out_ch3 !== exp_px.out_ch3) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp_px, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pbm_pkg::pbm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pbm_pkg::pbm_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  blend_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int request_count = 0;

  always #6 clk = ~clk;

  pixel_blend_mode_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pbm_pkg::REG_MODE:  sb.mode = val[3:0];
      pbm_pkg::REG_GAIN:  sb.gain = val[15:0];
      pbm_pkg::REG_BIAS:  sb.bias = val[10:0];
      pbm_pkg::REG_ALPHA: sb.alpha = val[8:0];
      pbm_pkg::REG_CH_A:  sb.ch_a = val[2:0];
      default:            sb.ch_b = val[2:0];
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves the clock edge at which the last request was accepted unconsumed,
  // so valid drops there only if no further request follows in the same step
  task automatic send_pixel(pbm_pkg::pbm_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    sb.note_request(d);
    request_count++;
  endtask

  function automatic pbm_pkg::pbm_in_t rand_pixel();
    pbm_pkg::pbm_in_t d;
    d = {$urandom, $urandom};
    case ($urandom_range(9))
      0: d = '0;
      1: d = '1;
      2: d.b_ch0 = '0;
      3: begin d.b_ch3 = 8'd255; d.b_ch1 = 8'd127; end
      4: d.b_ch2 = 8'd128;
      default: ;
    endcase
    return d;
  endfunction

  task automatic random_config(int phase);
    write_reg(pbm_pkg::REG_MODE, $urandom_range(15));
    case ($urandom_range(5))
      0: write_reg(pbm_pkg::REG_GAIN, 0);
      1: write_reg(pbm_pkg::REG_GAIN, 16'hFFFF);
      default: write_reg(pbm_pkg::REG_GAIN, $urandom_range(65535));
    endcase
    case ($urandom_range(5))
      0: write_reg(pbm_pkg::REG_BIAS, 11'h400);
      1: write_reg(pbm_pkg::REG_BIAS, 11'h3FF);
      2: write_reg(pbm_pkg::REG_BIAS, 11'h7FF);
      3: write_reg(pbm_pkg::REG_BIAS, $urandom_range(2047));
      default: write_reg(pbm_pkg::REG_BIAS, 0);
    endcase
    write_reg(pbm_pkg::REG_ALPHA,
              (phase % 3 == 0) ? $urandom_range(511) : $urandom_range(256));
    write_reg(pbm_pkg::REG_CH_A,
              (phase % 4 == 0) ? $urandom_range(7) : $urandom_range(4, 1));
    write_reg(pbm_pkg::REG_CH_B,
              (phase % 5 == 0) ? $urandom_range(7) : $urandom_range(4, 1));
  endtask

  initial begin
    pbm_pkg::pbm_in_t d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every mode on the extremes at reset settings
    for (int m = 0; m < 16; m++) begin
      write_reg(pbm_pkg::REG_MODE, m);
      send_pixel('0);
      send_pixel({8'd255, 8'd0, 8'd128, 8'd77, 8'd0, 8'd255, 8'd127, 8'd200});
      wait_drained();
    end
    write_reg(pbm_pkg::REG_MODE, pbm_pkg::MODE_COMPOSITE);
    write_reg(pbm_pkg::REG_CH_B, 3);
    send_pixel('1);
    wait_drained();
    write_reg(pbm_pkg::REG_CH_B, 0);
    write_reg(pbm_pkg::REG_CH_A, 7);
    write_reg(pbm_pkg::REG_MODE, pbm_pkg::MODE_LERP);
    write_reg(pbm_pkg::REG_ALPHA, 9'd511);
    send_pixel({$urandom, $urandom});
    wait_drained();
    write_reg(pbm_pkg::REG_CH_A, 0);
    send_pixel('1);
    wait_drained();
    write_reg(pbm_pkg::REG_MODE, pbm_pkg::MODE_SUB_SCALED);
    write_reg(pbm_pkg::REG_GAIN, 16'hFFFF);
    write_reg(pbm_pkg::REG_BIAS, 11'h400);
    write_reg(pbm_pkg::REG_CH_A, 4);
    write_reg(pbm_pkg::REG_CH_B, 4);
    send_pixel({32'h00FF7F10, 32'hFF00FF00});
    wait_drained();
    write_reg(pbm_pkg::REG_BIAS, 11'h3FF);
    send_pixel({32'h00FF7F10, 32'hFF00FF00});
    wait_drained();
    write_reg(pbm_pkg::REG_GAIN, 0);
    write_reg(pbm_pkg::REG_BIAS, 0);
    send_pixel('1);
    wait_drained();

    for (int phase = 0; phase < 16; phase++) begin
      random_config(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 86; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 86; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      if (phase == 4) hold_cycles = 300;
      for (int k = 0; k < 50; k++) begin
        d = rand_pixel();
        send_pixel(d);
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pbm_pkg.sv
rtl/pbm_lane.sv
rtl/pixel_blend_mode_unit.sv
tb/pixel_blend_mode_unit_tb.sv
